[design/disk_rsa_placement_macros.svh]
// assertion macros for the disk placement block
// no dependencies; users need clk and rst_n in scope
`ifndef DISK_RSA_PLACEMENT_MACROS_SVH
`define DISK_RSA_PLACEMENT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock edge
`define DRSA_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("disk placement check failed");
// consequent holds in the same cycle as the antecedent
`define DRSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("disk placement check failed");
// consequent holds in the cycle after the antecedent
`define DRSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("disk placement check failed");
`else
`define DRSA_ASSERT_NOW(label, expr)
`define DRSA_ASSERT_IMP(label, ante, cons)
`define DRSA_ASSERT_NXT(label, ante, cons)
`endif
`endif

[design/drsa_pkg.sv]
// shared types and constants for the disk placement block
// no dependencies
package drsa_pkg;

  // sizing
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int RAND_W     = 16;
  localparam int OUT_W      = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int PROD_W     = RAND_W + SPAN_W;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int D2_W       = 2 * COORD_BITS + 1;
  localparam int WORD_W     = 2 * COORD_BITS;

  // register field widths
  localparam int RADIUS_W = 15;
  localparam int TARGET_W = 11;
  localparam int STEPS_W  = 31;
  localparam int PCNT_W   = 11;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1638);
  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(1024);
  localparam logic [STEPS_W-1:0]  LIMIT_RST  = STEPS_W'(100000);

  // fixed point constants
  localparam logic [SPAN_W-1:0] ONE_FX = SPAN_W'(1) << COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;

  // control from sequencer to distance pipeline
  typedef struct packed {
    logic issue;
    logic flush;
  } dist_ctl_t;

  // status from distance pipeline to sequencer
  typedef struct packed {
    logic busy;
    logic hit;
  } dist_sts_t;

endpackage

[design/drsa_dist.sv]
// distance check pipeline: one stored centre per cycle against the candidate
// depends on drsa_pkg
module drsa_dist import drsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dist_ctl_t         ctl,
  input  coord_t            cand_x,
  input  coord_t            cand_y,
  input  logic [WORD_W-1:0] rdata,
  input  logic [D2_W-1:0]   d2min,
  output dist_sts_t         sts
);

  logic            s1_v_r;
  logic            s2_v_r;
  logic [SQ_W-1:0] sqx_r;
  logic [SQ_W-1:0] sqy_r;
  coord_t          mem_x;
  coord_t          mem_y;
  coord_t          dx;
  coord_t          dy;
  logic [D2_W-1:0] d2;

  // absolute differences against the entry just read
  assign mem_x = rdata[WORD_W-1:COORD_BITS];
  assign mem_y = rdata[COORD_BITS-1:0];
  assign dx    = (cand_x > mem_x) ? cand_x - mem_x : mem_x - cand_x;
  assign dy    = (cand_y > mem_y) ? cand_y - mem_y : mem_y - cand_y;

  // valid tracking, read data lands in the cycle after the issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= ctl.issue & ~ctl.flush;
      s2_v_r <= s1_v_r & ~ctl.flush;
    end
  end

  // squares registered before the sum
  always_ff @(posedge clk) begin
    sqx_r <= SQ_W'(dx) * SQ_W'(dx);
    sqy_r <= SQ_W'(dy) * SQ_W'(dy);
  end

  // overlap when strictly closer than two radii
  assign d2       = D2_W'(sqx_r) + D2_W'(sqy_r);
  assign sts.hit  = s2_v_r && (d2 < d2min);
  assign sts.busy = s1_v_r | s2_v_r;

endmodule

[design/disk_rsa_placement.sv]
// Item steps IDLE, MUL, MAP, SCAN, WRITE, DONE; no SCAN with an empty store, IDLE to DONE once
// finished; the scan reads one stored centre per cycle from the centre memory until a hit.
// Throughput: one item at a time, next item taken once the result is in the output register.
// Reset: synchronous active low; clears counts and registers to their defaults, the centre
// memory is left as is since entries are read only below the stored count.
// depends on drsa_pkg, drsa_dist and disk_rsa_placement_macros.svh
`include "disk_rsa_placement_macros.svh"
module disk_rsa_placement import drsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAND_W-1:0]     in_rand_x,
  input  logic [RAND_W-1:0]     in_rand_y,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [OUT_W-1:0]      out_cand_x,
  output logic [OUT_W-1:0]      out_cand_y,
  output logic [PCNT_W-1:0]     out_placed_count,
  output logic                  out_finished,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_MAP   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam coord_t RMAX = (COORD_BITS)'((1 << (COORD_BITS - 1)) - 1);

  // configuration registers
  logic [RADIUS_W-1:0] cfg_radius_r;
  logic [TARGET_W-1:0] cfg_target_r;
  logic [STEPS_W-1:0]  cfg_limit_r;
  logic                cfg_wr;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;

  // item payload
  logic [RAND_W-1:0] ux_r, uy_r;
  logic [PROD_W-1:0] prodx_r, prody_r;
  logic [SQ_W-1:0]   rsq_r;
  coord_t            cx_r, cy_r;
  logic [D2_W-1:0]   d2min_r;
  logic              acc_r;

  // result register
  logic              out_acc_r;
  logic [OUT_W-1:0]  out_cx_r, out_cy_r;
  logic [PCNT_W-1:0] out_cnt_r;
  logic              out_fin_r;

  // centre memory, x in the upper half of each word
  logic [WORD_W-1:0] mem [MAX_POINTS];
  logic [WORD_W-1:0] rdata_r;
  logic              rd_en;
  logic              wr_en;

  coord_t           eff_r;
  logic [SPAN_W-1:0] span;
  logic [CNT_W-1:0] eff_tgt;
  logic             fin;
  logic             in_acc;
  logic             issue_done;
  logic             scan_end;
  logic             out_load;
  dist_ctl_t        dctl;
  dist_sts_t        dsts;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r <= RADIUS_RST;
      cfg_target_r <= TARGET_RST;
      cfg_limit_r  <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_RADIUS: cfg_radius_r <= cfg_pwdata[RADIUS_W-1:0];
        REG_TARGET: cfg_target_r <= cfg_pwdata[TARGET_W-1:0];
        REG_LIMIT:  cfg_limit_r  <= cfg_pwdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RADIUS: cfg_prdata = CFG_DATA_W'(cfg_radius_r);
      REG_TARGET: cfg_prdata = CFG_DATA_W'(cfg_target_r);
      REG_LIMIT:  cfg_prdata = CFG_DATA_W'(cfg_limit_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // effective radius and target, saturated
  assign eff_r   = (32'(cfg_radius_r) > 32'(RMAX)) ? RMAX : COORD_BITS'(cfg_radius_r);
  assign span    = ONE_FX - {eff_r, 1'b0};
  assign eff_tgt = (32'(cfg_target_r) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(cfg_target_r);
  assign fin     = (count_r != '0) &&
                   ((32'(count_r) >= 32'(eff_tgt)) || (steps_r >= cfg_limit_r));

  // handshakes
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // scan control
  assign issue_done = (issue_r == count_r);
  assign rd_en      = (state_r == ST_SCAN) && !issue_done && !hit_r && !dsts.hit;
  assign scan_end   = (state_r == ST_SCAN) && (hit_r || (issue_done && !dsts.busy));
  assign wr_en      = (state_r == ST_WRITE) && acc_r && (32'(count_r) < 32'(MAX_POINTS));
  assign dctl.issue = rd_en;
  assign dctl.flush = (state_r != ST_SCAN);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    issue_nxt     = issue_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = fin ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_MAP;
      end
      ST_MAP: begin
        issue_nxt = '0;
        hit_nxt   = 1'b0;
        state_nxt = (count_r == '0) ? ST_WRITE : ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        hit_nxt = hit_r | dsts.hit;
        if (scan_end) begin
          steps_nxt = steps_r + STEPS_W'(1);
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (wr_en) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      issue_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      issue_r     <= issue_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // candidate mapping: multiply, then add the radius offset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ux_r <= in_rand_x;
      uy_r <= in_rand_y;
    end
    if (state_r == ST_MUL) begin
      prodx_r <= PROD_W'(ux_r) * PROD_W'(span);
      prody_r <= PROD_W'(uy_r) * PROD_W'(span);
      rsq_r   <= SQ_W'(eff_r) * SQ_W'(eff_r);
    end
    if (in_acc && fin) begin
      cx_r  <= '0;
      cy_r  <= '0;
      acc_r <= 1'b0;
    end else if (state_r == ST_MAP) begin
      cx_r    <= eff_r + COORD_BITS'(prodx_r >> RAND_W);
      cy_r    <= eff_r + COORD_BITS'(prody_r >> RAND_W);
      d2min_r <= D2_W'(rsq_r) << 2;
      acc_r   <= 1'b1;
    end else if (scan_end) begin
      acc_r <= ~hit_r;
    end
  end

  // centre memory, written at the end of an item, read during the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= {cx_r, cy_r};
    end
    if (rd_en) begin
      rdata_r <= mem[issue_r[ADDR_W-1:0]];
    end
  end

  drsa_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (dctl),
    .cand_x (cx_r),
    .cand_y (cy_r),
    .rdata  (rdata_r),
    .d2min  (d2min_r),
    .sts    (dsts)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r <= acc_r;
      out_cx_r  <= OUT_W'(cx_r);
      out_cy_r  <= OUT_W'(cy_r);
      out_cnt_r <= PCNT_W'(count_r);
      out_fin_r <= fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_cand_x       = out_cx_r;
  assign out_cand_y       = out_cy_r;
  assign out_placed_count = out_cnt_r;
  assign out_finished     = out_fin_r;

  // checks
  `DRSA_ASSERT_NOW(a_count_bound, 32'(count_r) <= 32'(MAX_POINTS))
  `DRSA_ASSERT_IMP(a_read_below_count, rd_en, issue_r < count_r)
  `DRSA_ASSERT_NXT(a_count_only_on_write, state_r != ST_WRITE, $stable(count_r))
  `DRSA_ASSERT_NXT(a_steps_only_on_scan, state_r != ST_SCAN, $stable(steps_r))

endmodule
